/* src/llat_pkg.sv */
// Shared types and constants for the life-like automaton torus step block.
// Used by the cell unit, the top level and the testbench; depends on nothing else.
package llat_pkg;

  // Default grid storage size.
  localparam int DefMaxWidth  = 64;
  localparam int DefMaxHeight = 64;

  // Rule word: birth bits for dead cells, then survival bits for live cells.
  localparam int RuleW       = 18;
  localparam int SurviveBase = 9;
  localparam int CountW      = 4;
  localparam int RuleIdxW    = 5;

  // Configuration register widths and reset values.
  localparam int GridDimW = 7;
  localparam logic [RuleW-1:0]    RuleReset   = 18'd6152;
  localparam logic [GridDimW-1:0] WidthReset  = 7'd64;
  localparam logic [GridDimW-1:0] HeightReset = 7'd64;

  // APB port geometry.
  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  // Register indexes (byte address is four times the index).
  typedef enum logic [1:0] {
    REG_RULE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  // Operation codes of an input word.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

  // Input word.
  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       write_value;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic cell_value;
    logic step_done;
  } out_word_t;

endpackage

/* src/llat_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on no package; used for the current and next generation grids.
module llat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/llat_cell_unit.sv */
// Neighbor count and rule lookup for one cell from three buffered rows.
// Depends on llat_pkg for the rule layout constants.
module llat_cell_unit #(
  parameter int MAX_WIDTH = llat_pkg::DefMaxWidth
) (
  input  logic [MAX_WIDTH-1:0]                               row_above_i,
  input  logic [MAX_WIDTH-1:0]                               row_center_i,
  input  logic [MAX_WIDTH-1:0]                               row_below_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] x_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] x_left_i,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] x_right_i,
  input  logic                                               above_same_i,
  input  logic                                               below_same_i,
  input  logic [llat_pkg::RuleW-1:0]                         rule_i,
  output logic                                               alive_o
);
  import llat_pkg::*;

  logic [7:0]          taps;
  logic [CountW-1:0]   count;
  logic [RuleIdxW-1:0] rule_idx;
  logic                left_self;
  logic                right_self;
  logic                self_alive;

  // On narrow grids the wrapped columns can land on the cell itself.
  assign left_self  = (x_left_i == x_i);
  assign right_self = (x_right_i == x_i);
  assign self_alive = row_center_i[x_i];

  // A wrapped tap that lands on the cell itself is masked out; every other
  // tap counts, even when two taps land on the same neighbor.
  always_comb begin
    taps[0] = row_above_i[x_left_i]   & ~(above_same_i & left_self);
    taps[1] = row_above_i[x_i]        & ~above_same_i;
    taps[2] = row_above_i[x_right_i]  & ~(above_same_i & right_self);
    taps[3] = row_center_i[x_left_i]  & ~left_self;
    taps[4] = row_center_i[x_right_i] & ~right_self;
    taps[5] = row_below_i[x_left_i]   & ~(below_same_i & left_self);
    taps[6] = row_below_i[x_i]        & ~below_same_i;
    taps[7] = row_below_i[x_right_i]  & ~(below_same_i & right_self);
  end

  // Population count of the eight taps.
  always_comb begin
    count = '0;
    for (int i = 0; i < 8; i++) begin
      count = count + CountW'(taps[i]);
    end
  end

  // Birth bits for dead cells, survival bits for live cells.
  always_comb begin
    if (self_alive) begin
      rule_idx = RuleIdxW'(SurviveBase) + RuleIdxW'(count);
    end else begin
      rule_idx = RuleIdxW'(count);
    end
  end

  assign alive_o = rule_i[rule_idx];

endmodule

/* src/life_like_automaton_torus_step.sv */
// Top level of the life-like automaton torus step block.
// Depends on llat_pkg, llat_ram and llat_cell_unit.
//
// Keeps a MAX_WIDTH by MAX_HEIGHT one-bit grid in two row-wide RAMs and
// handles one word at a time. After reset a clearing pass writes MAX_HEIGHT
// rows, one per cycle, before the first word is taken. A cell write or read
// goes through a row read state and a modify state before the result state;
// a write or read outside the used grid, or the unused operation code, goes
// straight to the result state. In a generation advance, for each row the
// sequencer loads the row above, the row and the row below into buffers,
// the shared neighbor unit then decides one cell per cycle, the new row goes
// to the scratch RAM, and a final pass copies the new rows of the used grid
// back, each with a read state and a write state. The result word is held
// in an output register, so a finished word waits there while the next
// input word is taken. Configuration lies on an APB port: rule number at
// 0x0, grid width at 0x4, grid height at 0x8.
module life_like_automaton_torus_step #(
  parameter int MAX_WIDTH  = llat_pkg::DefMaxWidth,
  parameter int MAX_HEIGHT = llat_pkg::DefMaxHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input word channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  llat_pkg::in_word_t            in_data_i,
  // Result word channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output llat_pkg::out_word_t           out_data_o,
  // APB configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [llat_pkg::ApbAddrW-1:0] paddr,
  input  logic [llat_pkg::ApbDataW-1:0] pwdata,
  output logic [llat_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import llat_pkg::*;

  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int NWX = $clog2(MAX_WIDTH + 1);
  localparam int NWY = $clog2(MAX_HEIGHT + 1);

  // Sequencer states, one-hot.
  typedef enum logic [12:0] {
    ST_CLEAR    = 13'h0001,
    ST_IDLE     = 13'h0002,
    ST_CELL_RD  = 13'h0004,
    ST_CELL_MOD = 13'h0008,
    ST_LOAD_A   = 13'h0010,
    ST_LOAD_C   = 13'h0020,
    ST_LOAD_B   = 13'h0040,
    ST_LOAD_END = 13'h0080,
    ST_GEN_CELL = 13'h0100,
    ST_GEN_WR   = 13'h0200,
    ST_COPY_RD  = 13'h0400,
    ST_COPY_WR  = 13'h0800,
    ST_RESP     = 13'h1000
  } state_e;

  state_e state_q, state_d;

  logic [RuleW-1:0]    rule_q;
  logic [GridDimW-1:0] width_q;
  logic [GridDimW-1:0] height_q;

  logic [YW-1:0] y_q, y_d;
  logic [XW-1:0] x_q, x_d;
  logic          out_valid_q, out_valid_d;

  logic [1:0]    item_op_q, item_op_d;
  logic [XW-1:0] item_x_q, item_x_d;
  logic [YW-1:0] item_y_q, item_y_d;
  logic          item_wv_q, item_wv_d;

  logic [MAX_WIDTH-1:0] row_a_q, row_a_d;
  logic [MAX_WIDTH-1:0] row_c_q, row_c_d;
  logic [MAX_WIDTH-1:0] row_b_q, row_b_d;
  logic [MAX_WIDTH-1:0] next_row_q, next_row_d;
  out_word_t            res_q, res_d;
  out_word_t            out_q, out_d;

  logic [NWX-1:0] used_w;
  logic [NWY-1:0] used_h;
  logic [XW-1:0]  last_x;
  logic [YW-1:0]  last_y;
  logic [YW-1:0]  y_above;
  logic [YW-1:0]  y_below;
  logic [XW-1:0]  x_left;
  logic [XW-1:0]  x_right;
  logic           item_inside;

  logic                 cur_we;
  logic [YW-1:0]        cur_waddr;
  logic [MAX_WIDTH-1:0] cur_wdata;
  logic [YW-1:0]        cur_raddr;
  logic [MAX_WIDTH-1:0] cur_rdata;
  logic                 nxt_we;
  logic [YW-1:0]        nxt_raddr;
  logic [MAX_WIDTH-1:0] nxt_rdata;
  logic [MAX_WIDTH-1:0] mod_row;
  logic                 unit_alive;
  logic                 cfg_write;

  // Grid size in use: zero counts as one, larger than storage is clamped.
  always_comb begin
    if (width_q == '0) begin
      used_w = NWX'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      used_w = NWX'(MAX_WIDTH);
    end else begin
      used_w = NWX'(width_q);
    end
    if (height_q == '0) begin
      used_h = NWY'(1);
    end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
      used_h = NWY'(MAX_HEIGHT);
    end else begin
      used_h = NWY'(height_q);
    end
  end

  assign last_x = XW'(used_w - NWX'(1));
  assign last_y = YW'(used_h - NWY'(1));

  // Wrapped neighbor rows and columns of the cell being worked on.
  assign y_above = (y_q == '0) ? last_y : y_q - YW'(1);
  assign y_below = (y_q == last_y) ? '0 : y_q + YW'(1);
  assign x_left  = (x_q == '0) ? last_x : x_q - XW'(1);
  assign x_right = (x_q == last_x) ? '0 : x_q + XW'(1);

  assign item_inside = (32'(in_data_i.cell_x) < 32'(used_w)) &&
                       (32'(in_data_i.cell_y) < 32'(used_h));

  // Row with the addressed cell replaced, for a cell write.
  always_comb begin
    mod_row           = cur_rdata;
    mod_row[item_x_q] = item_wv_q;
  end

  // Configuration registers.
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_q   <= RuleReset;
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_RULE:   rule_q   <= pwdata[RuleW-1:0];
        REG_WIDTH:  width_q  <= pwdata[GridDimW-1:0];
        REG_HEIGHT: height_q <= pwdata[GridDimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RULE:   prdata = ApbDataW'(rule_q);
      REG_WIDTH:  prdata = ApbDataW'(width_q);
      REG_HEIGHT: prdata = ApbDataW'(height_q);
      default:    prdata = '0;
    endcase
  end

  // Sequencer and RAM port control.
  always_comb begin
    state_d     = state_q;
    y_d         = y_q;
    x_d         = x_q;
    item_op_d   = item_op_q;
    item_x_d    = item_x_q;
    item_y_d    = item_y_q;
    item_wv_d   = item_wv_q;
    row_a_d     = row_a_q;
    row_c_d     = row_c_q;
    row_b_d     = row_b_q;
    next_row_d  = next_row_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cur_we      = 1'b0;
    cur_waddr   = y_q;
    cur_wdata   = '0;
    cur_raddr   = y_q;
    nxt_we      = 1'b0;
    nxt_raddr   = y_q;

    unique case (state_q)
      ST_CLEAR: begin
        cur_we = 1'b1;
        if (y_q == YW'(MAX_HEIGHT - 1)) begin
          y_d     = '0;
          state_d = ST_IDLE;
        end else begin
          y_d = y_q + YW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          item_op_d = in_data_i.operation;
          item_x_d  = XW'(in_data_i.cell_x);
          item_y_d  = YW'(in_data_i.cell_y);
          item_wv_d = in_data_i.write_value;
          res_d     = '0;
          if (in_data_i.operation == OP_STEP) begin
            y_d     = '0;
            state_d = ST_LOAD_A;
          end else if ((in_data_i.operation == OP_WRITE ||
                        in_data_i.operation == OP_READ) && item_inside) begin
            state_d = ST_CELL_RD;
          end else begin
            state_d = ST_RESP;
          end
        end
      end
      ST_CELL_RD: begin
        cur_raddr = item_y_q;
        state_d   = ST_CELL_MOD;
      end
      ST_CELL_MOD: begin
        if (item_op_q == OP_WRITE) begin
          cur_we           = 1'b1;
          cur_waddr        = item_y_q;
          cur_wdata        = mod_row;
          res_d.cell_value = item_wv_q;
        end else begin
          res_d.cell_value = cur_rdata[item_x_q];
        end
        state_d = ST_RESP;
      end
      ST_LOAD_A: begin
        cur_raddr = y_above;
        state_d   = ST_LOAD_C;
      end
      ST_LOAD_C: begin
        cur_raddr = y_q;
        row_a_d   = cur_rdata;
        state_d   = ST_LOAD_B;
      end
      ST_LOAD_B: begin
        cur_raddr = y_below;
        row_c_d   = cur_rdata;
        state_d   = ST_LOAD_END;
      end
      ST_LOAD_END: begin
        // Columns outside the used grid keep their state.
        row_b_d    = cur_rdata;
        next_row_d = row_c_q;
        x_d        = '0;
        state_d    = ST_GEN_CELL;
      end
      ST_GEN_CELL: begin
        next_row_d[x_q] = unit_alive;
        if (x_q == last_x) begin
          state_d = ST_GEN_WR;
        end else begin
          x_d = x_q + XW'(1);
        end
      end
      ST_GEN_WR: begin
        nxt_we = 1'b1;
        if (y_q == last_y) begin
          y_d     = '0;
          state_d = ST_COPY_RD;
        end else begin
          y_d     = y_q + YW'(1);
          state_d = ST_LOAD_A;
        end
      end
      ST_COPY_RD: begin
        nxt_raddr = y_q;
        state_d   = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        cur_we    = 1'b1;
        cur_wdata = nxt_rdata;
        if (y_q == last_y) begin
          y_d             = '0;
          res_d.step_done = 1'b1;
          state_d         = ST_RESP;
        end else begin
          y_d     = y_q + YW'(1);
          state_d = ST_COPY_RD;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      y_q         <= '0;
      x_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      y_q         <= y_d;
      x_q         <= x_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers and row buffers.
  always_ff @(posedge clk_i) begin
    item_op_q  <= item_op_d;
    item_x_q   <= item_x_d;
    item_y_q   <= item_y_d;
    item_wv_q  <= item_wv_d;
    row_a_q    <= row_a_d;
    row_c_q    <= row_c_d;
    row_b_q    <= row_b_d;
    next_row_q <= next_row_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  // Current generation grid, one row per entry.
  llat_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_cur_ram (
    .clk_i  (clk_i),
    .we_i   (cur_we),
    .waddr_i(cur_waddr),
    .wdata_i(cur_wdata),
    .raddr_i(cur_raddr),
    .rdata_o(cur_rdata)
  );

  // Scratch grid for the generation being built.
  llat_ram #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_nxt_ram (
    .clk_i  (clk_i),
    .we_i   (nxt_we),
    .waddr_i(y_q),
    .wdata_i(next_row_q),
    .raddr_i(nxt_raddr),
    .rdata_o(nxt_rdata)
  );

  // Shared neighbor count and rule unit.
  llat_cell_unit #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_cell_unit (
    .row_above_i (row_a_q),
    .row_center_i(row_c_q),
    .row_below_i (row_b_q),
    .x_i         (x_q),
    .x_left_i    (x_left),
    .x_right_i   (x_right),
    .above_same_i(y_above == y_q),
    .below_same_i(y_below == y_q),
    .rule_i      (rule_q),
    .alive_o     (unit_alive)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A result word never reports a cell value and a finished advance at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.cell_value && out_data_o.step_done))
    else $error("result word carries both cell value and step done");

  // Once a word is taken, the next one waits until this one is finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word taken while one is in progress");

  // The column counter stays inside the used grid width.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN_CELL) |-> (32'(x_q) < 32'(used_w)))
    else $error("column counter left the used grid");

  // The current grid is only written by clearing, a cell write or the copy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_we |-> (state_q == ST_CLEAR || state_q == ST_CELL_MOD ||
                state_q == ST_COPY_WR))
    else $error("current grid written outside its write states");

  // Each copy write uses the row read in the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY_WR) |-> ($past(state_q) == ST_COPY_RD))
    else $error("copy write without a preceding read");

endmodule

/* dv/life_like_automaton_torus_step_tb.sv */
// Self-checking testbench for life_like_automaton_torus_step.
// Depends on llat_pkg and the block's RTL. It runs a directed table, then random phases with
// random grid settings, and checks every result word against a grid predictor or a pinned table value.
`timescale 1ns / 100ps

module life_like_automaton_torus_step_tb;
  import llat_pkg::*;

  localparam int MaxCols = DefMaxWidth;
  localparam int MaxRows = DefMaxHeight;
  localparam logic [1:0] OpUnused = 2'd3;

  // One row of the directed table: a register write or an input word.
  typedef struct {
    bit          is_cfg;
    reg_idx_e    cfg_reg;
    logic [31:0] cfg_value;
    in_word_t    word;
    bit          pinned;
    out_word_t   known;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_word_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b1;
  out_word_t           out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ApbAddrW-1:0] paddr = '0;
  logic [ApbDataW-1:0] pwdata = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // Predictor state: the cell grid and the register copies.
  bit                  cell_grid [MaxRows][MaxCols];
  logic [RuleW-1:0]    rule_set = RuleReset;
  logic [GridDimW-1:0] width_reg = WidthReset;
  logic [GridDimW-1:0] height_reg = HeightReset;

  out_word_t grid_replies [$];
  stim_row_t directed_rows [$];
  bit        word_pinned = 1'b0;
  out_word_t word_known = '0;
  int        words_sent = 0;
  int        results_taken = 0;
  int        failures = 0;
  bit        calm = 1'b0;
  int        ready_hold = 0;

  life_like_automaton_torus_step dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk_i = ~clk_i;

  // A size register of 0 counts as 1 and anything above the storage counts as the maximum.
  function automatic int used_span(logic [GridDimW-1:0] code, int limit);
    if (code == 0) return 1;
    if (code > limit) return limit;
    return code;
  endfunction

  // One generation over the used grid; cells outside it keep their state.
  function automatic void advance_grid(int cols, int rows);
    bit fresh [MaxRows][MaxCols];
    int live;
    int u;
    int v;
    int bit_sel;
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        live = 0;
        for (int du = 0; du < 3; du++) begin
          u = (x + cols - 1 + du) % cols;
          for (int dv = 0; dv < 3; dv++) begin
            v = (y + rows - 1 + dv) % rows;
            // A wrapped position on the cell itself never counts.
            if (u == x && v == y) continue;
            live += cell_grid[v][u];
          end
        end
        bit_sel = cell_grid[y][x] ? SurviveBase + live : live;
        fresh[y][x] = rule_set[bit_sel];
      end
    end
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        cell_grid[y][x] = fresh[y][x];
      end
    end
  endfunction

  // Applies one input word to the grid copy and returns the result word it should give.
  function automatic out_word_t predict_grid_op(in_word_t w);
    int        cols;
    int        rows;
    bit        in_grid;
    out_word_t r;
    cols = used_span(width_reg, MaxCols);
    rows = used_span(height_reg, MaxRows);
    in_grid = (w.cell_x < cols) && (w.cell_y < rows);
    r = '0;
    case (w.operation)
      OP_WRITE: begin
        if (in_grid) begin
          cell_grid[w.cell_y][w.cell_x] = w.write_value;
          r.cell_value = w.write_value;
        end
      end
      OP_READ: begin
        if (in_grid) r.cell_value = cell_grid[w.cell_y][w.cell_x];
      end
      OP_STEP: begin
        advance_grid(cols, rows);
        r.step_done = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result check first, then the prediction for a word taken at the same edge.
  always @(posedge clk_i) begin
    out_word_t due;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_taken++;
        if (grid_replies.size() == 0) begin
          $error("result word %b arrived with nothing expected", out_data_o);
          failures++;
        end else begin
          due = grid_replies.pop_front();
          if (out_data_o.cell_value !== due.cell_value) begin
            $error("cell_value: expected %0b, got %0b", due.cell_value, out_data_o.cell_value);
            failures++;
          end
          if (out_data_o.step_done !== due.step_done) begin
            $error("step_done: expected %0b, got %0b", due.step_done, out_data_o.step_done);
            failures++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        due = predict_grid_op(in_data_i);
        if (word_pinned) due = word_known;
        grid_replies.push_back(due);
      end
    end
  end

  // Receiver stalls in random bursts, none once the run is calm.
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      ready_hold <= $urandom_range(0, 18);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Offers one word, after an optional random gap, and waits until it is taken.
  task automatic send_word(in_word_t w, bit pinned, out_word_t known);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    word_pinned <= pinned;
    word_known <= known;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // Holds the sender off until every word sent has given its result.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (results_taken != words_sent) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the predictor copy follows the write.
  task automatic apb_write(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RULE:   rule_set = value[RuleW-1:0];
      REG_WIDTH:  width_reg = value[GridDimW-1:0];
      REG_HEIGHT: height_reg = value[GridDimW-1:0];
      default: ;
    endcase
  endtask

  function automatic void add_cfg(reg_idx_e idx, logic [31:0] value);
    stim_row_t row;
    row = '{default: '0, cfg_reg: idx};
    row.is_cfg = 1'b1;
    row.cfg_value = value;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_row(logic [1:0] op, int x, int y, bit wv,
                                  bit pinned, bit cv, bit sd);
    stim_row_t row;
    row = '{default: '0, cfg_reg: REG_RULE};
    row.word = '{operation: op, cell_x: 6'(x), cell_y: 6'(y), write_value: wv};
    row.pinned = pinned;
    row.known = '{cell_value: cv, step_done: sd};
    directed_rows.push_back(row);
  endfunction

  // Grid size code for a random phase: mostly small, sometimes full, zero or too large.
  function automatic logic [GridDimW-1:0] pick_span();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return GridDimW'($urandom_range(65, 127));
    if (pick == 2) return 7'd64;
    return GridDimW'($urandom_range(1, 12));
  endfunction

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    in_word_t w;
    int       cols;
    int       rows;
    int       pick;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset grid with B3/S23 at 64 by 64: corner cells that touch across the wrap.
    add_row(OP_READ, 0, 0, 0, 1, 0, 0);
    add_row(OP_READ, 63, 63, 0, 1, 0, 0);
    add_row(OP_WRITE, 63, 63, 1, 1, 1, 0);
    add_row(OP_WRITE, 0, 0, 1, 1, 1, 0);
    add_row(OP_WRITE, 1, 0, 1, 1, 1, 0);
    add_row(OP_READ, 63, 63, 0, 1, 1, 0);
    add_row(OP_STEP, 0, 0, 0, 1, 0, 1);
    add_row(OP_READ, 0, 0, 0, 0, 0, 0);
    add_row(OP_READ, 0, 63, 0, 0, 0, 0);
    add_row(OpUnused, 63, 63, 1, 1, 0, 0);
    // Single cell grid from zero sizes, every rule bit set: the cell never sees itself.
    add_cfg(REG_RULE, 32'h3FFFF);
    add_cfg(REG_WIDTH, 32'd0);
    add_cfg(REG_HEIGHT, 32'd0);
    add_row(OP_WRITE, 0, 0, 0, 1, 0, 0);
    add_row(OP_STEP, 0, 0, 0, 1, 0, 1);
    add_row(OP_READ, 0, 0, 0, 0, 0, 0);
    add_row(OP_READ, 1, 0, 0, 1, 0, 0);
    add_row(OP_WRITE, 63, 0, 1, 1, 0, 0);
    // Two by three grid: a wrapped neighbor counts once per occurrence.
    add_cfg(REG_RULE, 32'h00204);
    add_cfg(REG_WIDTH, 32'd2);
    add_cfg(REG_HEIGHT, 32'd3);
    add_row(OP_WRITE, 1, 0, 1, 1, 1, 0);
    add_row(OP_STEP, 0, 0, 0, 1, 0, 1);
    add_row(OP_READ, 0, 0, 0, 0, 0, 0);
    add_row(OP_READ, 1, 0, 0, 0, 0, 0);
    // Oversized codes clamp to 64 by 64; rule zero clears every cell.
    add_cfg(REG_RULE, 32'h0);
    add_cfg(REG_WIDTH, 32'd100);
    add_cfg(REG_HEIGHT, 32'd127);
    add_row(OP_STEP, 0, 0, 0, 1, 0, 1);
    add_row(OP_READ, 63, 63, 0, 1, 0, 0);
    add_row(OP_READ, 0, 0, 0, 1, 0, 0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle();
        apb_write(directed_rows[i].cfg_reg, directed_rows[i].cfg_value);
      end else begin
        send_word(directed_rows[i].word, directed_rows[i].pinned, directed_rows[i].known);
      end
    end

    // Random phases, each with its own rule and grid size; the last one runs without gaps.
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      calm = (phase == 7);
      apb_write(REG_RULE, ($urandom_range(0, 3) == 0) ? 32'(RuleReset)
                                                       : $urandom_range(0, 18'h3FFFF));
      apb_write(REG_WIDTH, 32'(pick_span()));
      apb_write(REG_HEIGHT, 32'(pick_span()));
      cols = used_span(width_reg, MaxCols);
      rows = used_span(height_reg, MaxRows);
      for (int n = 0; n < 15; n++) begin
        pick = $urandom_range(0, 19);
        w.write_value = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) begin
          w.cell_x = 6'($urandom_range(0, 63));
          w.cell_y = 6'($urandom_range(0, 63));
        end else begin
          w.cell_x = 6'($urandom_range(0, cols - 1));
          w.cell_y = 6'($urandom_range(0, rows - 1));
        end
        if (pick < 10) w.operation = OP_WRITE;
        else if (pick < 16) w.operation = OP_READ;
        else if (pick < 19) w.operation = OP_STEP;
        else w.operation = OpUnused;
        send_word(w, 1'b0, '0);
      end
    end

    settle();
    // Room for a stray word to show up after the last expected one.
    repeat (5000) @(posedge clk_i);
    if (grid_replies.size() != 0) begin
      $error("%0d expected result words never arrived", grid_replies.size());
      failures++;
    end
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #50ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
